### rtl/gkb_pkg.sv
// ----------------------------------------------------------------------------
// gkb_pkg
// Types and constants shared by the gf(2) kernel basis controller, datapath
// and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gkb_pkg;

   localparam int ROW_W       = 16;
   localparam int COL_W       = 4;
   localparam int NCOL_W      = 5;
   localparam int DIM_W       = 5;
   localparam int DEF_MAX_COLUMNS = 16;
   localparam int DEF_MAX_ROWS    = 32;
   localparam logic [NCOL_W-1:0] COLUMN_COUNT_RESET = 5'd16;

   typedef struct packed {
      logic [ROW_W-1:0] row_bits;
      logic             last_row;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0] kernel_vector;
      logic [DIM_W-1:0] kernel_dimension;
      logic             row_overflow;
      logic             last_vector;
   } rsp_type;

   typedef struct packed {
      logic             load;
      logic             prep;
      logic             search;
      logic             elim;
      logic             emit;
      logic             finish;
      logic [COL_W-1:0] col;
   } cmd_type;

   typedef struct packed {
      logic last_col;
      logic n_zero;
      logic dim_zero;
      logic col_pivot;
   } sts_type;

endpackage

`default_nettype wire

### rtl/gkb_ctrl.sv
// ----------------------------------------------------------------------------
// gkb_ctrl
// Sequencer: row load, per-column pivot search and elimination, then a column
// scan that emits one basis vector per free column, or a zero vector if none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gkb_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic            last_row,
   input  wire gkb_pkg::sts_type sts,
   output gkb_pkg::cmd_type     cmd,
   output logic                 busy
);
   import gkb_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PREP   = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_ELIM   = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;

   always_comb begin
      state_in   = state_ff;
      col_in     = col_ff;
      cmd        = '0;
      cmd.col    = col_ff;
      busy       = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (last_row) begin
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            col_in   = '0;
            state_in = sts.n_zero ? S_EMIT : S_SEARCH;
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = S_ELIM;
         end
         S_ELIM: begin
            cmd.elim = 1'b1;
            if (sts.last_col) begin
               col_in   = '0;
               state_in = S_EMIT;
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_EMIT: begin
            if (sts.dim_zero) begin
               cmd.emit   = 1'b1;
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.emit = !sts.col_pivot;
               if (sts.last_col) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
      end
   end

endmodule

`default_nettype wire

### rtl/gkb_datapath.sv
// ----------------------------------------------------------------------------
// gkb_datapath
// Row store with per-row live bits, pivot select and parallel xor
// elimination, per-column pivot rows, and the registered result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gkb_datapath #(
   parameter int MAX_COLUMNS = gkb_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = gkb_pkg::DEF_MAX_ROWS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gkb_pkg::cmd_type              cmd,
   input  wire gkb_pkg::req_type              req_item,
   input  wire logic                          csr_we,
   input  wire logic [gkb_pkg::NCOL_W-1:0]    csr_wdata,
   output gkb_pkg::sts_type                   sts,
   output gkb_pkg::rsp_type                   rsp_item,
   output logic                               rsp_valid
);
   import gkb_pkg::*;

   localparam int CNT_W = $clog2(MAX_ROWS + 1);
   localparam int IDX_W = $clog2(MAX_ROWS);
   localparam int COLS  = (MAX_COLUMNS < ROW_W) ? MAX_COLUMNS : ROW_W;
   localparam logic [NCOL_W-1:0] COLS_V = NCOL_W'(COLS);
   localparam logic [CNT_W-1:0]  FULL_V = CNT_W'(MAX_ROWS);

   logic [NCOL_W-1:0]   ncol_ff, ncol_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;
   logic [ROW_W-1:0]    rows_ff [MAX_ROWS];
   logic [ROW_W-1:0]    rows_in [MAX_ROWS];
   logic [MAX_ROWS-1:0] live_ff, live_in;
   logic [MAX_ROWS-1:0] sel_ff, sel_in;
   logic [ROW_W-1:0]    pv_ff, pv_in;
   logic                found_ff, found_in;
   logic [ROW_W-1:0]    piv_ff, piv_in;
   logic [ROW_W-1:0]    prow_ff [ROW_W];
   logic [ROW_W-1:0]    prow_in [ROW_W];
   logic [DIM_W-1:0]    rank_ff, rank_in;
   logic [DIM_W-1:0]    k_ff, k_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [NCOL_W-1:0]   n_eff;
   logic [DIM_W-1:0]    dim;
   logic [MAX_ROWS-1:0] cand, low;
   logic [ROW_W-1:0]    pv_sel;
   logic [ROW_W-1:0]    vec;
   logic                full;

   always_comb begin
      n_eff = (ncol_ff > COLS_V) ? COLS_V : ncol_ff;
      dim   = n_eff - rank_ff;
      full  = (cnt_ff == FULL_V);
      for (int r = 0; r < MAX_ROWS; r++) begin
         cand[r] = live_ff[r] & rows_ff[r][cmd.col];
      end
      low    = cand & (~cand + 1'b1);
      pv_sel = '0;
      for (int r = 0; r < MAX_ROWS; r++) begin
         if (low[r]) begin
            pv_sel = pv_sel | rows_ff[r];
         end
      end
      vec = '0;
      for (int b = 0; b < ROW_W; b++) begin
         if (piv_ff[b] && prow_ff[b][cmd.col]) begin
            vec[b] = 1'b1;
         end
      end
      vec[cmd.col] = 1'b1;
      sts.last_col  = ({1'b0, cmd.col} == (n_eff - 1'b1));
      sts.n_zero    = (n_eff == '0);
      sts.dim_zero  = (dim == '0);
      sts.col_pivot = piv_ff[cmd.col];
   end

   always_comb begin
      ncol_in      = csr_we ? csr_wdata : ncol_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      rows_in      = rows_ff;
      live_in      = live_ff;
      sel_in       = sel_ff;
      pv_in        = pv_ff;
      found_in     = found_ff;
      piv_in       = piv_ff;
      prow_in      = prow_ff;
      rank_in      = rank_ff;
      k_in         = k_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;

      if (cmd.load) begin
         if (!full) begin
            rows_in[cnt_ff[IDX_W-1:0]] = req_item.row_bits;
            live_in[cnt_ff[IDX_W-1:0]] = 1'b1;
            cnt_in                     = cnt_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.prep) begin
         piv_in  = '0;
         rank_in = '0;
         k_in    = '0;
      end

      if (cmd.search) begin
         sel_in   = low;
         pv_in    = pv_sel;
         found_in = |cand;
      end

      if (cmd.elim && found_ff) begin
         for (int r = 0; r < MAX_ROWS; r++) begin
            if (sel_ff[r]) begin
               live_in[r] = 1'b0;
            end else if (live_ff[r] && rows_ff[r][cmd.col]) begin
               rows_in[r] = rows_ff[r] ^ pv_ff;
            end
         end
         for (int c = 0; c < ROW_W; c++) begin
            if (piv_ff[c] && prow_ff[c][cmd.col]) begin
               prow_in[c] = prow_ff[c] ^ pv_ff;
            end
         end
         piv_in[cmd.col]  = 1'b1;
         prow_in[cmd.col] = pv_ff;
         rank_in          = rank_ff + 1'b1;
      end

      if (cmd.emit) begin
         rsp_valid_in            = 1'b1;
         rsp_in.kernel_vector    = sts.dim_zero ? '0 : vec;
         rsp_in.kernel_dimension = dim;
         rsp_in.row_overflow     = ovf_ff;
         rsp_in.last_vector      = sts.dim_zero || ((k_ff + 1'b1) == dim);
         k_in                    = k_ff + 1'b1;
      end

      if (cmd.finish) begin
         cnt_in  = '0;
         ovf_in  = 1'b0;
         live_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ncol_ff      <= COLUMN_COUNT_RESET;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         live_ff      <= '0;
         found_ff     <= 1'b0;
         piv_ff       <= '0;
         rank_ff      <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ncol_ff      <= ncol_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         live_ff      <= live_in;
         found_ff     <= found_in;
         piv_ff       <= piv_in;
         rank_ff      <= rank_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rows_ff <= rows_in;
      sel_ff  <= sel_in;
      pv_ff   <= pv_in;
      prow_ff <= prow_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_item  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/gf2_kernel_basis.sv
// ----------------------------------------------------------------------------
// gf2_kernel_basis
// Nullspace basis of a gf(2) matrix: rows load one per cycle while busy is low,
// the matrix goes to reduced row echelon form, one basis vector per free column.
//
//   channel  ports                         transfer
//   input    start, busy, req_item         start high while busy low
//   result   rsp_valid, rsp_item           rsp_valid high, one cycle each
//   config   csr_we, csr_wdata             csr_we high
//
// after the last row the matrix is reduced (a prep step, then a search step and an
// xor step per column) and then the columns are scanned, one result per free
// column in ascending order (a single zero result for an empty kernel). busy
// stays high from the last row until the final result is registered; results
// cannot be held off by the receiver.
// synchronous reset returns to idle with an empty row store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gf2_kernel_basis #(
   parameter int MAX_COLUMNS = gkb_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = gkb_pkg::DEF_MAX_ROWS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire gkb_pkg::req_type           req_item,
   output logic                            rsp_valid,
   output gkb_pkg::rsp_type                rsp_item,
   input  wire logic                       csr_we,
   input  wire logic [gkb_pkg::NCOL_W-1:0] csr_wdata
);
   import gkb_pkg::*;

   cmd_type cmd;
   sts_type sts;

   gkb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .last_row (req_item.last_row),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   gkb_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .sts       (sts),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid)
   );

endmodule

`default_nettype wire
